// ----- rtl/lcd_init_sequence_interpreter_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef LCD_INIT_SEQUENCE_INTERPRETER_MACROS_SVH
`define LCD_INIT_SEQUENCE_INTERPRETER_MACROS_SVH

// Plain property, sampled on clk, off during reset.
`define LISI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define LISI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LISI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lisi_pkg.sv -----
`default_nettype none

package lisi_pkg;

    localparam int WORD_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int KIND_W         = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int DEF_MAX_PARAMS = 32;

    localparam logic [WORD_W-1:0] DEF_MSDELAY_CODE   = 32'd256;
    localparam logic [WORD_W-1:0] DEF_USDELAY_CODE   = 32'd257;
    localparam logic [WORD_W-1:0] DEF_RESETLINE_CODE = 32'd258;

    localparam logic [CFG_IDX_W-1:0] CFG_MSDELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USDELAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESETLINE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_BYTE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MS    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_US    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESET = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

    typedef struct packed {
        logic              busy;
        logic              emit;
        logic [BYTE_W-1:0] data;
        logic              dc;
        logic              last;
    } burst_stat_t;

endpackage

`default_nettype wire

// ----- rtl/lisi_if.sv -----
`default_nettype none

interface lisi_word_if
    import lisi_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] seq_word;
    logic              seq_start;

    modport source (output valid, output seq_word, output seq_start, input ready);
    modport sink   (input valid, input seq_word, input seq_start, output ready);
endinterface

interface lisi_result_if
    import lisi_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] out_kind;
    logic [BYTE_W-1:0] bus_byte;
    logic              dc_level;
    logic [WORD_W-1:0] delay_amount;
    logic              reset_level;
    logic              run_last;

    modport source (
        output valid, output out_kind, output bus_byte, output dc_level,
        output delay_amount, output reset_level, output run_last, input ready
    );
    modport sink (
        input valid, input out_kind, input bus_byte, input dc_level,
        input delay_amount, input reset_level, input run_last, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/lisi_cmd_buf.sv -----
`default_nettype none

`include "lcd_init_sequence_interpreter_macros.svh"

module lisi_cmd_buf
    import lisi_pkg::*;
#(
    parameter int MAX_PARAMS = DEF_MAX_PARAMS,
    localparam int ADDR_W    = $clog2(MAX_PARAMS + 1),
    localparam int CNT_W     = $clog2(MAX_PARAMS + 2)
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [BYTE_W-1:0] wr_data,
    input  wire logic              start,
    input  wire logic [CNT_W-1:0]  len,
    input  wire logic              take,
    output burst_stat_t            stat
);

    localparam int DEPTH = MAX_PARAMS + 1;

    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_READ = 3'b010,
        BS_LOAD = 3'b100
    } bstate_t;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    bstate_t           state_reg, state_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  ptr_inc;
    logic              at_last;

    assign ptr_inc = ptr_reg + CNT_W'(1);
    assign at_last = (ptr_inc == len_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == BS_READ)
        begin
            rd_data_reg <= mem[ptr_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        len_next   = len_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (start)
                begin
                    len_next   = len;
                    ptr_next   = '0;
                    state_next = BS_READ;
                end
            end
            BS_READ:
            begin
                state_next = BS_LOAD;
            end
            BS_LOAD:
            begin
                if (take)
                begin
                    ptr_next   = ptr_inc;
                    state_next = at_last ? BS_IDLE : BS_READ;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            ptr_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            len_reg   <= len_next;
        end
    end

    assign stat.busy = (state_reg != BS_IDLE);
    assign stat.emit = (state_reg == BS_LOAD) && take;
    assign stat.data = rd_data_reg;
    assign stat.dc   = (ptr_reg != '0);
    assign stat.last = at_last;

    `LISI_ASSERT_IMP(a_ptr_in_range, stat.busy, ptr_reg < len_reg, "burst pointer past length")
    `LISI_ASSERT_IMP(a_start_idle, start, state_reg == BS_IDLE, "burst started while busy")
    `LISI_ASSERT_NXT(a_last_ends, stat.emit && stat.last, state_reg == BS_IDLE,
                     "burst did not end on last byte")

endmodule

`default_nettype wire

// ----- rtl/lcd_init_sequence_interpreter.sv -----
// A delay, reset or error result is in the output register in the cycle after its word is taken.
// Throughput: one word per cycle outside bursts while output drains; words without results too.
// Each command burst byte takes a command store read, then a load; no input is taken meanwhile.
// Reset: asynchronous, active low; codes return to 256/257/258, reset line present.
// Reset also clears phase, counts, halt and output valid; the command store is not cleared.
`default_nettype none

`include "lcd_init_sequence_interpreter_macros.svh"

module lcd_init_sequence_interpreter
    import lisi_pkg::*;
#(
    parameter int MAX_PARAMS = DEF_MAX_PARAMS
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    lisi_word_if.sink                 words,
    lisi_result_if.source             results
);

    localparam int ADDR_W = $clog2(MAX_PARAMS + 1);
    localparam int CNT_W  = $clog2(MAX_PARAMS + 2);

    typedef enum logic [5:0] {
        PH_CMD    = 6'b000001,
        PH_COUNT  = 6'b000010,
        PH_PARAMS = 6'b000100,
        PH_MS     = 6'b001000,
        PH_US     = 6'b010000,
        PH_RST    = 6'b100000
    } phase_t;

    logic [WORD_W-1:0] msdelay_code_reg;
    logic [WORD_W-1:0] usdelay_code_reg;
    logic [WORD_W-1:0] resetline_code_reg;
    logic              resetline_present_reg;

    phase_t            phase_reg, phase_next, ph;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  wanted_reg, wanted_next;
    logic              halted_reg, halted_next;
    logic [CNT_W-1:0]  held_inc;

    logic              accept;
    logic              live;
    logic              slot_free;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              burst_start;
    logic [CNT_W-1:0]  burst_len;
    burst_stat_t       stat;

    logic              res_load;
    logic [KIND_W-1:0] res_kind;
    logic [WORD_W-1:0] res_amount;
    logic              res_level;

    logic              res_valid_reg;
    logic [KIND_W-1:0] res_kind_reg;
    logic [BYTE_W-1:0] res_byte_reg;
    logic              res_dc_reg;
    logic [WORD_W-1:0] res_amount_reg;
    logic              res_level_reg;
    logic              res_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msdelay_code_reg      <= DEF_MSDELAY_CODE;
            usdelay_code_reg      <= DEF_USDELAY_CODE;
            resetline_code_reg    <= DEF_RESETLINE_CODE;
            resetline_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MSDELAY:   msdelay_code_reg      <= cfg_data;
                CFG_USDELAY:   usdelay_code_reg      <= cfg_data;
                CFG_RESETLINE: resetline_code_reg    <= cfg_data;
                CFG_PRESENT:   resetline_present_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign slot_free    = !res_valid_reg || results.ready;
    assign words.ready  = slot_free && !stat.busy;
    assign accept       = words.valid && words.ready;
    assign ph           = words.seq_start ? PH_CMD : phase_reg;
    assign live         = words.seq_start || !halted_reg;
    assign held_inc     = held_reg + CNT_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        wanted_next = wanted_reg;
        halted_next = halted_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        burst_start = 1'b0;
        burst_len   = held_reg;
        res_load    = 1'b0;
        res_kind    = KIND_ERROR;
        res_amount  = '0;
        res_level   = 1'b0;
        if (accept)
        begin
            phase_next  = ph;
            halted_next = halted_reg && !words.seq_start;
            if (live)
            begin
                unique case (ph)
                    PH_CMD:
                    begin
                        priority if (words.seq_word == msdelay_code_reg)
                        begin
                            phase_next = PH_MS;
                        end
                        else if (words.seq_word == usdelay_code_reg)
                        begin
                            phase_next = PH_US;
                        end
                        else if (words.seq_word == resetline_code_reg)
                        begin
                            phase_next = PH_RST;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            held_next  = CNT_W'(1);
                            phase_next = PH_COUNT;
                        end
                    end
                    PH_COUNT:
                    begin
                        if (words.seq_word > WORD_W'(MAX_PARAMS))
                        begin
                            res_load    = 1'b1;
                            res_kind    = KIND_ERROR;
                            halted_next = 1'b1;
                            phase_next  = PH_CMD;
                        end
                        else
                        begin
                            wanted_next = words.seq_word[CNT_W-1:0];
                            if (words.seq_word == '0)
                            begin
                                burst_start = 1'b1;
                                burst_len   = held_reg;
                                phase_next  = PH_CMD;
                            end
                            else
                            begin
                                phase_next = PH_PARAMS;
                            end
                        end
                    end
                    PH_PARAMS:
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = held_reg[ADDR_W-1:0];
                        held_next = held_inc;
                        if (held_reg >= wanted_reg)
                        begin
                            burst_start = 1'b1;
                            burst_len   = held_inc;
                            phase_next  = PH_CMD;
                        end
                    end
                    PH_MS:
                    begin
                        res_load   = 1'b1;
                        res_kind   = KIND_MS;
                        res_amount = words.seq_word;
                        phase_next = PH_CMD;
                    end
                    PH_US:
                    begin
                        res_load   = 1'b1;
                        res_kind   = KIND_US;
                        res_amount = words.seq_word;
                        phase_next = PH_CMD;
                    end
                    PH_RST:
                    begin
                        res_load   = resetline_present_reg;
                        res_kind   = KIND_RESET;
                        res_level  = (words.seq_word != '0);
                        phase_next = PH_CMD;
                    end
                    default:
                    begin
                        phase_next = PH_CMD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CMD;
            held_reg      <= '0;
            wanted_reg    <= '0;
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            wanted_reg <= wanted_next;
            halted_reg <= halted_next;
            if (res_load || stat.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.emit)
        begin
            res_kind_reg   <= KIND_BYTE;
            res_byte_reg   <= stat.data;
            res_dc_reg     <= stat.dc;
            res_amount_reg <= '0;
            res_level_reg  <= 1'b0;
            res_last_reg   <= stat.last;
        end
        else if (res_load)
        begin
            res_kind_reg   <= res_kind;
            res_byte_reg   <= '0;
            res_dc_reg     <= 1'b0;
            res_amount_reg <= res_amount;
            res_level_reg  <= res_level;
            res_last_reg   <= 1'b1;
        end
    end

    lisi_cmd_buf #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_cmd_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (words.seq_word[BYTE_W-1:0]),
        .start   (burst_start),
        .len     (burst_len),
        .take    (slot_free),
        .stat    (stat)
    );

    assign results.valid        = res_valid_reg;
    assign results.out_kind     = res_kind_reg;
    assign results.bus_byte     = res_byte_reg;
    assign results.dc_level     = res_dc_reg;
    assign results.delay_amount = res_amount_reg;
    assign results.reset_level  = res_level_reg;
    assign results.run_last     = res_last_reg;

    `LISI_ASSERT_IMP(a_no_accept_in_burst, stat.emit, !accept,
                     "word taken while a burst byte loads")
    `LISI_ASSERT_NXT(a_halt_holds, accept && halted_reg && !words.seq_start,
                     $stable(phase_reg) && $stable(held_reg) && halted_reg,
                     "halted interpreter changed state")
    `LISI_ASSERT_IMP(a_burst_len, burst_start, burst_len != '0 && !res_load,
                     "empty burst or burst with direct result")

endmodule

`default_nettype wire
